// ----- hdl/elfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfd_pkg
// Shared types and constants of the escaped, length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package elfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 10;
  localparam int CNT_W       = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFD;
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hFC;
  localparam logic [BYTE_W-1:0] HIGH_BIT   = 8'h80;
  localparam logic [CNT_W-1:0]  CRC_LEN    = 17'd2;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    CMD_FLUSH,
    CMD_START,
    CMD_MARKER,
    CMD_DATA
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] stored_byte;
    logic [POS_W-1:0]  position;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ----- hdl/elfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfd_front
// Accepts input requests and classifies each into a parser command.
// ----------------------------------------------------------------------------
module elfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  elfd_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               push,
  output elfd_pkg::cmd_t     push_cmd
);

  logic           f_valid;
  logic           f_valid_next;
  elfd_pkg::cmd_t f_cmd;
  elfd_pkg::cmd_t f_cmd_next;
  logic           accept;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !q_full;
  assign push_cmd = f_cmd;

  always_comb begin
    f_cmd_next.data_byte = in_data.data_byte;
    if (in_data.operation == elfd_pkg::OP_FLUSH) begin
      f_cmd_next.kind = elfd_pkg::CMD_FLUSH;
    end else if (in_data.data_byte == elfd_pkg::START_BYTE) begin
      f_cmd_next.kind = elfd_pkg::CMD_START;
    end else if (in_data.data_byte == elfd_pkg::ESC_BYTE) begin
      f_cmd_next.kind = elfd_pkg::CMD_MARKER;
    end else begin
      f_cmd_next.kind = elfd_pkg::CMD_DATA;
    end
  end

  always_comb begin
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= f_cmd_next;
    end
  end

endmodule

// ----- hdl/elfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfd_queue
// Short command queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module elfd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  elfd_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output elfd_pkg::queue_status_t status,
  output elfd_pkg::cmd_t          head
);

  elfd_pkg::cmd_t                  mem [elfd_pkg::QUEUE_DEPTH];
  logic [elfd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [elfd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [elfd_pkg::QCNT_W-1:0]     count;
  logic [elfd_pkg::QCNT_W-1:0]     count_next;

  assign status.full  = count == elfd_pkg::QCNT_W'(elfd_pkg::QUEUE_DEPTH);
  assign status.valid = count != '0;
  assign head         = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.valid)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= elfd_pkg::QCNT_W'(elfd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hdl/elfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfd_back
// Frame parser: runs the commands, tracks length and fill, drives results.
// ----------------------------------------------------------------------------
module elfd_back #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                decode_escaped,
  input  logic                q_valid,
  input  elfd_pkg::cmd_t      q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output elfd_pkg::out_item_t out_data
);

  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [FILL_W-1:0] DEPTH_VAL = FILL_W'(BUFFER_DEPTH);

  elfd_pkg::phase_t               phase;
  elfd_pkg::phase_t               phase_next;
  elfd_pkg::phase_t               phase_mid;
  logic                           esc;
  logic                           esc_next;
  logic [FILL_W-1:0]              fill;
  logic [FILL_W-1:0]              fill_next;
  logic [FILL_W-1:0]              fill_base;
  logic [FILL_W-1:0]              fill_inc;
  logic [elfd_pkg::CNT_W-1:0]     exp_cnt;
  logic [elfd_pkg::CNT_W-1:0]     exp_cnt_next;
  logic [elfd_pkg::CNT_W-1:0]     data_cnt;
  logic [elfd_pkg::CNT_W-1:0]     data_cnt_next;
  logic [elfd_pkg::CNT_W-1:0]     data_cnt_inc;
  logic [elfd_pkg::BYTE_W-1:0]    byte_val;
  logic [elfd_pkg::BYTE_W-1:0]    len_byte;
  logic                           store;
  logic                           comp;
  logic                           emit;
  logic                           done;
  logic                           out_valid_next;
  elfd_pkg::out_item_t            res;

  assign pop          = q_valid && (!out_valid || !out_stall);
  assign fill_inc     = fill_base + 1'b1;
  assign data_cnt_inc = data_cnt + 1'b1;

  always_comb begin
    phase_next    = phase;
    phase_mid     = phase;
    esc_next      = esc;
    fill_next     = fill;
    fill_base     = fill;
    exp_cnt_next  = exp_cnt;
    data_cnt_next = data_cnt;
    byte_val      = q_cmd.data_byte;
    len_byte      = q_cmd.data_byte;
    store         = 1'b0;
    comp          = 1'b0;
    emit          = 1'b0;
    done          = 1'b0;
    case (q_cmd.kind)
      elfd_pkg::CMD_FLUSH: begin
        phase_next = elfd_pkg::PH_IDLE;
        fill_next  = '0;
        esc_next   = 1'b0;
      end
      elfd_pkg::CMD_START: begin
        esc_next  = 1'b0;
        phase_mid = elfd_pkg::PH_LEN_HI;
        fill_base = '0;
        byte_val  = elfd_pkg::START_BYTE;
        store     = 1'b1;
      end
      elfd_pkg::CMD_MARKER: begin
        esc_next = 1'b1;
        byte_val = elfd_pkg::ESC_BYTE;
        store    = !decode_escaped;
      end
      elfd_pkg::CMD_DATA: begin
        if (esc && decode_escaped) begin
          byte_val = q_cmd.data_byte | elfd_pkg::HIGH_BIT;
        end
        if (esc) begin
          len_byte = q_cmd.data_byte | elfd_pkg::HIGH_BIT;
        end
        if (phase != elfd_pkg::PH_IDLE) begin
          case (phase)
            elfd_pkg::PH_LEN_HI: begin
              exp_cnt_next = elfd_pkg::CNT_W'({len_byte, 8'h00});
              phase_mid    = elfd_pkg::PH_LEN_LO;
            end
            elfd_pkg::PH_LEN_LO: begin
              exp_cnt_next  = (exp_cnt | elfd_pkg::CNT_W'(len_byte)) + elfd_pkg::CRC_LEN;
              data_cnt_next = '0;
              phase_mid     = elfd_pkg::PH_DATA;
            end
            elfd_pkg::PH_DATA: begin
              data_cnt_next = data_cnt_inc;
              comp          = data_cnt_inc == exp_cnt;
            end
            default: begin
            end
          endcase
          esc_next = 1'b0;
          store    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (store) begin
      if (fill_base >= DEPTH_VAL) begin
        fill_next  = fill_base;
        phase_next = comp ? elfd_pkg::PH_IDLE : phase_mid;
      end else begin
        emit       = 1'b1;
        fill_next  = fill_inc;
        done       = comp || (fill_inc == DEPTH_VAL);
        phase_next = done ? elfd_pkg::PH_IDLE : phase_mid;
      end
    end
  end

  always_comb begin
    res.stored_byte = byte_val;
    res.position    = elfd_pkg::POS_W'(fill_base);
    res.frame_end   = done;
    if (pop) begin
      out_valid_next = emit;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= elfd_pkg::PH_IDLE;
      esc       <= 1'b0;
      fill      <= '0;
      exp_cnt   <= '0;
      data_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (pop) begin
        phase    <= phase_next;
        esc      <= esc_next;
        fill     <= fill_next;
        exp_cnt  <= exp_cnt_next;
        data_cnt <= data_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= res;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_VAL)
    else $error("fill count beyond buffer depth");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    pop && q_cmd.kind == elfd_pkg::CMD_FLUSH |=>
      fill == '0 && phase == elfd_pkg::PH_IDLE && !esc)
    else $error("flush did not clear parser");

  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    pop && q_cmd.kind == elfd_pkg::CMD_START |=>
      out_valid && out_data.stored_byte == elfd_pkg::START_BYTE &&
      out_data.position == '0 && phase == elfd_pkg::PH_LEN_HI)
    else $error("start byte not stored at position zero");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    pop && emit && done |=> phase == elfd_pkg::PH_IDLE)
    else $error("parser not idle after frame end");

endmodule

// ----- hdl/escaped_length_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_length_frame_deframer
// Byte-stuffed, length-prefixed frame deframer with decoupled front and back.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one request per accepted cycle (in_valid high, in_stall low),
//     carrying either a received byte or a flush of the parser.
//   out channel: zero or one result per request, the stored byte with its
//     buffer position and an end-of-frame flag, taken when out_stall is low.
//   cfg port: cfg_wr_en writes cfg_wr_data into decode_escaped; write only
//     while the block is idle.
// Throughput: one request per cycle while in_stall stays low.
// Result path: each result reaches out_valid through the classify register,
//   a queue entry, then the output register.
// Reset (rst, synchronous): parser idle, fill and counts zero, decoding off,
//   queue empty, no result pending.
// Receiver stall: the output register holds; commands collect in the
//   four-entry queue, and in_stall rises once the queue and classify
//   register are full.
// ----------------------------------------------------------------------------
module escaped_length_frame_deframer #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  elfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output elfd_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                    decode_escaped;
  logic                    push;
  logic                    pop;
  elfd_pkg::cmd_t          push_cmd;
  elfd_pkg::cmd_t          head;
  elfd_pkg::queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_escaped <= 1'b0;
    end else if (cfg_wr_en) begin
      decode_escaped <= cfg_wr_data;
    end
  end

  elfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_status.full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  elfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status),
    .head     (head)
  );

  elfd_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .decode_escaped (decode_escaped),
    .q_valid        (q_status.valid),
    .q_cmd          (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

// ----- test/deframe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the request, result and register ports of the frame deframer. It
// keeps its own copy of the parser state, works out the stored byte, buffer
// position and end-of-frame flag for every request that stores a byte, and
// compares each result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module deframe_checker #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  elfd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  elfd_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int                  fail_count,
  output int                  pending,
  output int                  result_count,
  output int                  frame_count
);

  logic                       decode_on;
  elfd_pkg::phase_t           phase;
  logic                       esc_pending;
  int unsigned                fill;
  logic [elfd_pkg::CNT_W-1:0] want_count;
  logic [elfd_pkg::CNT_W-1:0] got_count;
  elfd_pkg::out_item_t        stored_byte_q[$];

  function automatic bit predict_stored_byte(input elfd_pkg::in_item_t req,
                                             output elfd_pkg::out_item_t res);
    logic [elfd_pkg::BYTE_W-1:0] b;
    logic [elfd_pkg::BYTE_W-1:0] len_byte;
    bit                          by_length;
    bit                          last;
    b = req.data_byte;
    by_length = 1'b0;
    res = '0;
    if (req.operation == elfd_pkg::OP_FLUSH) begin
      phase = elfd_pkg::PH_IDLE;
      fill = 0;
      esc_pending = 1'b0;
      return 1'b0;
    end
    if (b == elfd_pkg::START_BYTE) begin
      fill = 0;
      esc_pending = 1'b0;
      phase = elfd_pkg::PH_LEN_HI;
    end else if (b == elfd_pkg::ESC_BYTE) begin
      esc_pending = 1'b1;
      if (decode_on) return 1'b0;
    end else begin
      if (esc_pending && decode_on) b = b | elfd_pkg::HIGH_BIT;
      if (phase == elfd_pkg::PH_IDLE) return 1'b0;
      len_byte = esc_pending ? (b | elfd_pkg::HIGH_BIT) : b;
      case (phase)
        elfd_pkg::PH_LEN_HI: begin
          want_count = {1'b0, len_byte, 8'h00};
          phase = elfd_pkg::PH_LEN_LO;
        end
        elfd_pkg::PH_LEN_LO: begin
          want_count = (want_count | elfd_pkg::CNT_W'(len_byte)) + elfd_pkg::CRC_LEN;
          got_count = '0;
          phase = elfd_pkg::PH_DATA;
        end
        default: begin
          got_count = got_count + 1'b1;
          by_length = (got_count == want_count);
        end
      endcase
      esc_pending = 1'b0;
    end
    // buffer already full: store is dropped
    if (fill >= BUFFER_DEPTH) begin
      if (by_length) phase = elfd_pkg::PH_IDLE;
      return 1'b0;
    end
    res.stored_byte = b;
    res.position = elfd_pkg::POS_W'(fill);
    fill++;
    last = by_length || (fill == BUFFER_DEPTH);
    if (last) phase = elfd_pkg::PH_IDLE;
    res.frame_end = last;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    elfd_pkg::out_item_t want;
    if (rst) begin
      decode_on = 1'b0;
      phase = elfd_pkg::PH_IDLE;
      esc_pending = 1'b0;
      fill = 0;
      want_count = '0;
      got_count = '0;
      stored_byte_q.delete();
      fail_count = 0;
      result_count = 0;
      frame_count = 0;
    end else begin
      if (cfg_wr_en) decode_on = cfg_wr_data;
      if (out_valid && !out_stall) begin
        result_count++;
        if (out_data.frame_end) frame_count++;
        if (stored_byte_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result: byte %02h pos %0d last %0d", $realtime,
                     out_data.stored_byte, out_data.position, out_data.frame_end);
        end else begin
          want = stored_byte_q.pop_front();
          if (want.stored_byte !== out_data.stored_byte ||
              want.position !== out_data.position ||
              want.frame_end !== out_data.frame_end) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected %02h/%0d/%0d, got %02h/%0d/%0d",
                       $realtime, want.stored_byte, want.position, want.frame_end,
                       out_data.stored_byte, out_data.position, out_data.frame_end);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_stored_byte(in_data, want)) stored_byte_q.push_back(want);
      end
    end
    pending = stored_byte_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame deframer with a short directed sequence, two long frames
// (one runs into the buffer depth, one has an escaped length), then random frames,
// broken frames, noise and flushes under both decode settings. Random idle
// bursts on both sides and one long output hold exercise back-pressure; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BUFFER_DEPTH     = 1024;
  localparam int RANDOM_REQUESTS  = 460;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int SETTLE_CYCLES    = 16;
  localparam int TIMEOUT_NS       = 5_000_000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  elfd_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  elfd_pkg::out_item_t out_data;
  logic                cfg_wr_en;
  logic                cfg_wr_data;

  int fail_count;
  int pending;
  int result_count;
  int frame_count;
  int request_count;
  int flush_count;
  int setting_count;
  bit bursts_on;
  bit hold_off_req;

  escaped_length_frame_deframer #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  deframe_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) frame_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count),
    .frame_count (frame_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // receiver side: random stall bursts and one long hold
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_request(input logic op, input logic [elfd_pkg::BYTE_W-1:0] b);
    elfd_pkg::in_item_t req;
    req.operation = op;
    req.data_byte = b;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    request_count++;
    if (op == elfd_pkg::OP_FLUSH) flush_count++;
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_decode(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  function automatic logic [elfd_pkg::BYTE_W-1:0] payload_byte;
    logic [elfd_pkg::BYTE_W-1:0] b;
    b = elfd_pkg::BYTE_W'($urandom_range(0, 255));
    if (b == elfd_pkg::START_BYTE || b == elfd_pkg::ESC_BYTE) b = b ^ 8'h10;
    return b;
  endfunction

  task automatic send_frame(input logic [elfd_pkg::BYTE_W-1:0] len_hi,
                            input logic [elfd_pkg::BYTE_W-1:0] len_lo,
                            input bit esc_lo, input int n_data, input bit with_escapes);
    int i;
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::START_BYTE);
    push_request(elfd_pkg::OP_BYTE, len_hi);
    if (esc_lo) push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, len_lo);
    for (i = 0; i < n_data; i++) begin
      if (with_escapes && $urandom_range(0, 7) == 0)
        push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
      push_request(elfd_pkg::OP_BYTE, payload_byte());
    end
  endtask

  task automatic random_burst;
    int pick;
    int len;
    int n;
    int i;
    pick = $urandom_range(0, 99);
    len = $urandom_range(0, 24);
    if (pick < 70) begin
      send_frame(8'h00, elfd_pkg::BYTE_W'(len), 1'b0, len + 2, 1'b1);
    end else if (pick < 72) begin
      send_frame(8'h00, elfd_pkg::BYTE_W'($urandom_range(0, 127)), 1'b1,
                 $urandom_range(0, 8), 1'b1);
      push_request(elfd_pkg::OP_FLUSH, elfd_pkg::BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      send_frame(8'h00, elfd_pkg::BYTE_W'(len), 1'b0, $urandom_range(0, len + 1), 1'b1);
      if ($urandom_range(0, 1) == 1)
        push_request(elfd_pkg::OP_FLUSH, elfd_pkg::BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        push_request(($urandom_range(0, 5) == 0) ? elfd_pkg::OP_FLUSH : elfd_pkg::OP_BYTE,
                     elfd_pkg::BYTE_W'($urandom_range(0, 255)));
    end else begin
      push_request(elfd_pkg::OP_FLUSH, elfd_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int ph;
    int base;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    bursts_on = 1'b0;
    hold_off_req = 1'b0;
    request_count = 0;
    flush_count = 0;
    setting_count = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, decoding off
    push_request(elfd_pkg::OP_FLUSH, 8'hFF);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_BYTE, 8'hFF);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h12);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::START_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_BYTE, 8'hFF);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::START_BYTE);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_FLUSH, 8'h00);

    // directed, decoding on
    write_decode(1'b1);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::START_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h00);
    push_request(elfd_pkg::OP_BYTE, 8'h01);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h05);
    push_request(elfd_pkg::OP_BYTE, 8'h7F);
    push_request(elfd_pkg::OP_BYTE, 8'hFF);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::START_BYTE);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h01);
    push_request(elfd_pkg::OP_FLUSH, 8'h55);

    // full buffer, then a dropped store past the end
    write_decode(1'b0);
    bursts_on = 1'b1;
    send_frame(8'h04, 8'h00, 1'b0, BUFFER_DEPTH - 3, 1'b0);
    push_request(elfd_pkg::OP_BYTE, elfd_pkg::ESC_BYTE);
    push_request(elfd_pkg::OP_BYTE, 8'h33);
    push_request(elfd_pkg::OP_FLUSH, 8'hAA);

    // escaped length byte ends the frame by length
    write_decode(1'b1);
    send_frame(8'h00, 8'h00, 1'b1, 130, 1'b0);

    base = request_count;
    for (ph = 0; ph < 6; ph++) begin
      write_decode(ph[0]);
      bursts_on = (ph != 2 && ph != 5);
      if (ph == 1) hold_off_req = 1'b1;
      while (request_count < base + (ph + 1) * RANDOM_REQUESTS / 6) random_burst();
    end

    settle();
    $display("covered %0d requests including %0d flushes over %0d decode settings",
             request_count, flush_count, setting_count + 1);
    $display("checked %0d results with %0d frame ends, %0d failures",
             result_count, frame_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- escaped_length_frame_deframer.f -----
hdl/elfd_pkg.sv
hdl/elfd_front.sv
hdl/elfd_queue.sv
hdl/elfd_back.sv
hdl/escaped_length_frame_deframer.sv
test/deframe_checker.sv
test/testbench.sv
